### design/pmp_pkg.sv
// ----------------------------------------------------------------------------
// pmp_pkg: shared definitions for the particle motion prediction block
// Field widths, register codes, the CORDIC arctangent table and the
// status record that the arithmetic units hand back to the sequencer.
// ----------------------------------------------------------------------------
package pmp_pkg;

  localparam int ANGLE_BITS_DEF     = 16;
  localparam int MAX_STEP_TICKS_DEF = 3072;
  localparam int ATAN_ENTRIES       = 24;

  localparam int POS_W   = 32;
  localparam int VEL_W   = 32;
  localparam int YAW_W   = 24;
  localparam int TIME_W  = 32;
  localparam int HEAD_W  = 16;

  // number of bits in the sine and cosine words fed to the rotation multiply
  localparam int MUL_STEPS = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_VEL_X    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_Y    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_YAW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TIME = 2'd3;

  // 0.60725 in Q1.30, the inverse CORDIC gain
  localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  // arctan(2^-i) with a full turn equal to 2^32
  function automatic logic [31:0] atan_lookup(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

### design/pmp_if.sv
// ----------------------------------------------------------------------------
// pmp_if: valid/ready channels of the particle motion prediction block
// pmp_in_if carries one particle word, pmp_out_if one moved particle word.
// ----------------------------------------------------------------------------
interface pmp_in_if import pmp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     first_in_step;
  logic [TIME_W-1:0]        step_time;
  logic signed [POS_W-1:0]  pos_x;
  logic signed [POS_W-1:0]  pos_y;
  logic [HEAD_W-1:0]        heading;

  modport source (output valid, first_in_step, step_time, pos_x, pos_y, heading,
                  input ready);
  modport sink   (input valid, first_in_step, step_time, pos_x, pos_y, heading,
                  output ready);
endinterface

interface pmp_out_if import pmp_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  new_x;
  logic signed [POS_W-1:0]  new_y;
  logic [HEAD_W-1:0]        new_heading;
  logic                     moved;

  modport source (output valid, new_x, new_y, new_heading, moved, input ready);
  modport sink   (input valid, new_x, new_y, new_heading, moved, output ready);
endinterface

### design/pmp_step_mul.sv
// ----------------------------------------------------------------------------
// pmp_step_mul: step increment multiplier
// Multiplies the three velocities by dt one dt bit per cycle, then rounds
// the products by 1/1024 and saturates (x, y) or wraps (yaw).
// ----------------------------------------------------------------------------
module pmp_step_mul import pmp_pkg::*; #(
  parameter int DT_BITS = 12
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [DT_BITS-1:0]       dt,
  input  logic signed [VEL_W-1:0]  vel_x,
  input  logic signed [VEL_W-1:0]  vel_y,
  input  logic signed [YAW_W-1:0]  vel_yaw,
  output unit_sts_t                sts,
  output logic signed [POS_W-1:0]  step_dx,
  output logic signed [POS_W-1:0]  step_dy,
  output logic [HEAD_W-1:0]        step_dyaw
);

  // at least eleven steps so the rounding bit and the 1/1024 shift exist
  localparam int DT_STEPS = (DT_BITS > 11) ? DT_BITS : 11;
  localparam int CNT_W    = $clog2(DT_STEPS + 1);
  localparam int HW       = VEL_W + 1;
  localparam int ACC_W    = HW + DT_STEPS;
  localparam int RW       = ACC_W - 9;
  localparam int LANES    = 3;

  logic [DT_STEPS-1:0] dt_sr_r;
  logic [CNT_W-1:0]    cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [ACC_W-1:0]    acc_r [LANES];
  logic [HW-1:0]       mcand [LANES];
  logic [HW:0]         sum   [LANES];
  logic [RW-1:0]       rnd   [LANES];
  logic [POS_W-1:0]    sat   [LANES];

  assign mcand[0] = {vel_x[VEL_W-1], vel_x};
  assign mcand[1] = {vel_y[VEL_W-1], vel_y};
  assign mcand[2] = {{(HW-YAW_W){vel_yaw[YAW_W-1]}}, vel_yaw};

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      sum[i] = {acc_r[i][ACC_W-1], acc_r[i][ACC_W-1 -: HW]}
             + (dt_sr_r[0] ? {mcand[i][HW-1], mcand[i]} : '0);
      // round half up: drop ten fraction bits, add the last one dropped
      rnd[i] = {acc_r[i][ACC_W-1], acc_r[i][ACC_W-1:10]} + {{(RW-1){1'b0}}, acc_r[i][9]};
      if ((&rnd[i][RW-1:POS_W-1]) || (~|rnd[i][RW-1:POS_W-1])) begin
        sat[i] = rnd[i][POS_W-1:0];
      end else if (rnd[i][RW-1]) begin
        sat[i] = {1'b1, {(POS_W-1){1'b0}}};
      end else begin
        sat[i] = {1'b0, {(POS_W-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DT_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift the low product bits out as each dt bit is consumed
  always_ff @(posedge clk) begin
    if (start) begin
      dt_sr_r <= DT_STEPS'(dt);
      for (int i = 0; i < LANES; i++) begin
        acc_r[i] <= '0;
      end
    end else if (busy_r) begin
      dt_sr_r <= {1'b0, dt_sr_r[DT_STEPS-1:1]};
      for (int i = 0; i < LANES; i++) begin
        acc_r[i] <= {sum[i], acc_r[i][DT_STEPS-1:1]};
      end
    end
  end

  assign sts.busy  = busy_r;
  assign sts.done  = done_r;
  assign step_dx   = sat[0];
  assign step_dy   = sat[1];
  assign step_dyaw = rnd[2][HEAD_W-1:0];

endmodule

### design/pmp_cordic.sv
// ----------------------------------------------------------------------------
// pmp_cordic: iterative sine and cosine of a particle heading
// One rotation per cycle, ANGLE_BITS rotations, results in Q1.30.
// ----------------------------------------------------------------------------
module pmp_cordic import pmp_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [HEAD_W-1:0]           heading,
  output unit_sts_t                   sts,
  output logic signed [MUL_STEPS-1:0] cos_q,
  output logic signed [MUL_STEPS-1:0] sin_q
);

  localparam int IT_W = $clog2(ANGLE_BITS + 1);
  localparam int CW   = 34;

  logic signed [CW-1:0] x_r, y_r, z_r;
  logic                 flip_r;
  logic [IT_W-1:0]      it_r;
  logic                 busy_r;
  logic                 done_r;

  logic [HEAD_W-1:0]    quad;
  logic [HEAD_W-1:0]    ang;
  logic signed [CW-1:0] xs, ys, at;
  logic signed [CW-1:0] x_fin, y_fin;

  // fold the left half plane onto the right one, negate at the end
  assign quad = heading + {2'b01, {(HEAD_W-2){1'b0}}};
  assign ang  = quad[HEAD_W-1] ? (heading ^ {1'b1, {(HEAD_W-1){1'b0}}}) : heading;

  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;
  assign at = $signed({2'b00, atan_lookup(5'(it_r))});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      it_r   <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        it_r   <= '0;
      end else if (busy_r) begin
        it_r <= it_r + 1'b1;
        if (it_r == IT_W'(ANGLE_BITS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r    <= $signed({2'b00, CORDIC_GAIN_Q30});
      y_r    <= '0;
      z_r    <= $signed({{2{ang[HEAD_W-1]}}, ang, 16'h0000});
      flip_r <= quad[HEAD_W-1];
    end else if (busy_r) begin
      if (!z_r[CW-1]) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  assign x_fin    = flip_r ? -x_r : x_r;
  assign y_fin    = flip_r ? -y_r : y_r;
  assign cos_q    = x_fin[MUL_STEPS-1:0];
  assign sin_q    = y_fin[MUL_STEPS-1:0];
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

### design/pmp_rot_mul.sv
// ----------------------------------------------------------------------------
// pmp_rot_mul: bit-serial rotation of the step increment
// Forms dx*sin + dy*cos and dx*cos - dy*sin one sine/cosine bit per cycle,
// keeping the full product so the 2^-30 rounding stays exact.
// ----------------------------------------------------------------------------
module pmp_rot_mul import pmp_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic signed [POS_W-1:0]     step_dx,
  input  logic signed [POS_W-1:0]     step_dy,
  input  logic signed [MUL_STEPS-1:0] cos_q,
  input  logic signed [MUL_STEPS-1:0] sin_q,
  output unit_sts_t                   sts,
  output logic signed [35:0]          move_x_hi,
  output logic                        move_x_rnd,
  output logic signed [35:0]          move_y_hi,
  output logic                        move_y_rnd
);

  localparam int HW    = POS_W + 2;
  localparam int ACC_W = HW + MUL_STEPS;
  localparam int CNT_W = $clog2(MUL_STEPS + 1);

  logic [MUL_STEPS-1:0] c_sr_r, s_sr_r;
  logic [ACC_W-1:0]     acc_x_r, acc_y_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic signed [HW-1:0] dx_e, dy_e, tx, ty, px, py;
  logic signed [HW:0]   sum_x, sum_y;
  logic                 sign_bit;

  assign dx_e     = HW'(step_dx);
  assign dy_e     = HW'(step_dy);
  assign sign_bit = (cnt_r == CNT_W'(1));

  always_comb begin
    tx = (s_sr_r[0] ? dx_e : '0) + (c_sr_r[0] ? dy_e : '0);
    ty = (c_sr_r[0] ? dx_e : '0) - (s_sr_r[0] ? dy_e : '0);
    // the top bit of a two's complement multiplier weighs negative
    px = sign_bit ? -tx : tx;
    py = sign_bit ? -ty : ty;
    sum_x = $signed({acc_x_r[ACC_W-1], acc_x_r[ACC_W-1 -: HW]}) + $signed({px[HW-1], px});
    sum_y = $signed({acc_y_r[ACC_W-1], acc_y_r[ACC_W-1 -: HW]}) + $signed({py[HW-1], py});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(MUL_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      c_sr_r  <= cos_q;
      s_sr_r  <= sin_q;
      acc_x_r <= '0;
      acc_y_r <= '0;
    end else if (busy_r) begin
      c_sr_r  <= {1'b0, c_sr_r[MUL_STEPS-1:1]};
      s_sr_r  <= {1'b0, s_sr_r[MUL_STEPS-1:1]};
      acc_x_r <= {sum_x, acc_x_r[MUL_STEPS-1:1]};
      acc_y_r <= {sum_y, acc_y_r[MUL_STEPS-1:1]};
    end
  end

  assign move_x_hi  = acc_x_r[ACC_W-1:30];
  assign move_x_rnd = acc_x_r[29];
  assign move_y_hi  = acc_y_r[ACC_W-1:30];
  assign move_y_rnd = acc_y_r[29];
  assign sts.busy   = busy_r;
  assign sts.done   = done_r;

endmodule

### design/particle_motion_prediction.sv
// ----------------------------------------------------------------------------
// particle_motion_prediction: particle filter prediction step
// Moves each particle by the latched body-frame step rotated by its heading.
// ----------------------------------------------------------------------------
// The block takes one particle word at a time and returns one result word
// for it. A word flagged first_in_step opens a prediction step: dt is the
// step time minus the stored last time, and the step is valid when
// 0 < dt <= MAX_STEP_TICKS. A valid step latches dx, dy and dyaw from the
// velocity registers and stores the step time; an invalid one passes every
// particle of the step through unchanged with moved low. A passing particle
// goes straight to the output stage; a moved particle runs the iterative
// CORDIC (one rotation a cycle) and then the bit-serial rotation multiply
// (one sine/cosine bit a cycle); a first word of a valid step first runs the
// bit-serial dt multiply. The next word is taken while a finished result
// still waits in the output register. Write the configuration only while
// no word is in flight; a reference_time write reloads the stored last time.
module particle_motion_prediction import pmp_pkg::*; #(
  parameter int ANGLE_BITS     = ANGLE_BITS_DEF,
  parameter int MAX_STEP_TICKS = MAX_STEP_TICKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  pmp_in_if.sink                in_ch,
  pmp_out_if.source             out_ch
);

  localparam int DT_BITS = $clog2(MAX_STEP_TICKS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_STEP   = 3'd1;
  localparam logic [2:0] ST_CORDIC = 3'd2;
  localparam logic [2:0] ST_ROT    = 3'd3;
  localparam logic [2:0] ST_FIN    = 3'd4;

  logic [2:0] state_r;

  // configuration
  logic signed [VEL_W-1:0] vel_x_r, vel_y_r;
  logic signed [YAW_W-1:0] vel_yaw_r;

  // step state
  logic [TIME_W-1:0]       last_time_r;
  logic                    step_valid_r;
  logic signed [POS_W-1:0] step_dx_r, step_dy_r;
  logic [HEAD_W-1:0]       step_dyaw_r;

  // particle in flight
  logic signed [POS_W-1:0] pos_x_r, pos_y_r;
  logic [HEAD_W-1:0]       heading_r;
  logic                    cordic_go_r;

  // output register
  logic                    out_valid_r;
  logic signed [POS_W-1:0] new_x_r, new_y_r;
  logic [HEAD_W-1:0]       new_heading_r;
  logic                    moved_r;

  logic                    in_fire;
  logic                    out_free;
  logic [TIME_W:0]         dt_full;
  logic                    dt_ok;

  unit_sts_t               step_sts, cordic_sts, rot_sts;
  logic                    step_start;
  logic signed [POS_W-1:0] mul_dx, mul_dy;
  logic [HEAD_W-1:0]       mul_dyaw;
  logic signed [MUL_STEPS-1:0] cos_q, sin_q;
  logic signed [35:0]      move_x_hi, move_y_hi;
  logic                    move_x_rnd, move_y_rnd;
  logic signed [36:0]      sum_x, sum_y;
  logic signed [POS_W-1:0] sat_x, sat_y;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  // plain difference, no wrap: a step time behind the last time is invalid
  assign dt_full = {1'b0, in_ch.step_time} - {1'b0, last_time_r};
  assign dt_ok   = !dt_full[TIME_W] && (dt_full != '0) &&
                   (dt_full <= (TIME_W+1)'(MAX_STEP_TICKS));

  assign step_start = in_fire && in_ch.first_in_step && dt_ok;

  pmp_step_mul #(
    .DT_BITS (DT_BITS)
  ) u_step_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (step_start),
    .dt        (dt_full[DT_BITS-1:0]),
    .vel_x     (vel_x_r),
    .vel_y     (vel_y_r),
    .vel_yaw   (vel_yaw_r),
    .sts       (step_sts),
    .step_dx   (mul_dx),
    .step_dy   (mul_dy),
    .step_dyaw (mul_dyaw)
  );

  pmp_cordic #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cordic_go_r),
    .heading (heading_r),
    .sts     (cordic_sts),
    .cos_q   (cos_q),
    .sin_q   (sin_q)
  );

  // the rotation multiply starts on the cycle the CORDIC results settle
  pmp_rot_mul u_rot_mul (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (cordic_sts.done),
    .step_dx    (step_dx_r),
    .step_dy    (step_dy_r),
    .cos_q      (cos_q),
    .sin_q      (sin_q),
    .sts        (rot_sts),
    .move_x_hi  (move_x_hi),
    .move_x_rnd (move_x_rnd),
    .move_y_hi  (move_y_hi),
    .move_y_rnd (move_y_rnd)
  );

  // position plus rounded move; the rounding bit rides in as a carry
  assign sum_x = {{5{pos_x_r[POS_W-1]}}, pos_x_r} + {move_x_hi[35], move_x_hi}
               + {36'd0, move_x_rnd};
  assign sum_y = {{5{pos_y_r[POS_W-1]}}, pos_y_r} + {move_y_hi[35], move_y_hi}
               + {36'd0, move_y_rnd};

  always_comb begin
    if ((&sum_x[36:31]) || (~|sum_x[36:31])) begin
      sat_x = sum_x[POS_W-1:0];
    end else begin
      sat_x = sum_x[36] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
    if ((&sum_y[36:31]) || (~|sum_y[36:31])) begin
      sat_y = sum_y[POS_W-1:0];
    end else begin
      sat_y = sum_y[36] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    end
  end

  // sequencer, step state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cordic_go_r  <= 1'b0;
      vel_x_r      <= '0;
      vel_y_r      <= '0;
      vel_yaw_r    <= '0;
      last_time_r  <= '0;
      step_valid_r <= 1'b0;
      step_dx_r    <= '0;
      step_dy_r    <= '0;
      step_dyaw_r  <= '0;
    end else begin
      cordic_go_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_VEL_X:    vel_x_r     <= cfg_data;
          REG_VEL_Y:    vel_y_r     <= cfg_data;
          REG_VEL_YAW:  vel_yaw_r   <= cfg_data[YAW_W-1:0];
          REG_REF_TIME: last_time_r <= cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.first_in_step) begin
              // evaluate the step time; an invalid step keeps the old latches
              step_valid_r <= dt_ok;
              if (dt_ok) begin
                last_time_r <= in_ch.step_time;
                state_r     <= ST_STEP;
              end else begin
                state_r <= ST_FIN;
              end
            end else if (step_valid_r) begin
              cordic_go_r <= 1'b1;
              state_r     <= ST_CORDIC;
            end else begin
              state_r <= ST_FIN;
            end
          end
        end
        ST_STEP: begin
          if (step_sts.done) begin
            step_dx_r   <= mul_dx;
            step_dy_r   <= mul_dy;
            step_dyaw_r <= mul_dyaw;
            cordic_go_r <= 1'b1;
            state_r     <= ST_CORDIC;
          end
        end
        ST_CORDIC: begin
          if (cordic_sts.done) begin
            state_r <= ST_ROT;
          end
        end
        ST_ROT: begin
          if (rot_sts.done) begin
            state_r <= ST_FIN;
          end
        end
        ST_FIN: begin
          // hold until the output register can take the word
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // capture the particle as it is accepted
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pos_x_r   <= in_ch.pos_x;
      pos_y_r   <= in_ch.pos_y;
      heading_r <= in_ch.heading;
    end
  end

  // output register: drop the word once taken, load a finished one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      if (step_valid_r) begin
        new_x_r       <= sat_x;
        new_y_r       <= sat_y;
        new_heading_r <= heading_r + step_dyaw_r;
        moved_r       <= 1'b1;
      end else begin
        new_x_r       <= pos_x_r;
        new_y_r       <= pos_y_r;
        new_heading_r <= heading_r;
        moved_r       <= 1'b0;
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.new_x       = new_x_r;
  assign out_ch.new_y       = new_y_r;
  assign out_ch.new_heading = new_heading_r;
  assign out_ch.moved       = moved_r;

  // the arithmetic units run one after another, never together
  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(cordic_sts.busy && rot_sts.busy) && !(step_sts.busy && cordic_sts.busy))
    else $error("arithmetic units busy at the same time");

  a_step_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    (step_sts.busy || step_sts.done) |-> (state_r == ST_STEP))
    else $error("step multiplier active outside the step state");

  a_bad_step_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_ch.first_in_step && !dt_ok) |=> (!step_valid_r && state_r == ST_FIN))
    else $error("invalid step time did not clear the step");

  a_rot_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    rot_sts.done |=> (state_r == ST_FIN))
    else $error("rotation result not handed to the output stage");

  a_last_time_src: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(last_time_r) |->
      $past((cfg_we && cfg_index == REG_REF_TIME) || step_start))
    else $error("last time changed without a write or a valid step");

endmodule

### sim/tb_particle_motion_prediction.sv
// ----------------------------------------------------------------------------
// tb_particle_motion_prediction: self-checking bench for the motion update
// Sends particle words under random valid/ready pauses, predicts every moved
// or passed particle with an independent fixed-point CORDIC model and checks
// each result word field by field, in order.
// ----------------------------------------------------------------------------
module tb_particle_motion_prediction;
  import pmp_pkg::*;

  // generous: well above the length of a legal run
  localparam int CYCLE_LIMIT  = 2_000_000;
  // a moved first word runs all three arithmetic units; leave room for stragglers
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_WORDS = 1650;
  localparam longint GAIN_Q30 = 64'sd652032874;

  typedef struct {
    bit                     first;
    bit [TIME_W-1:0]        stime;
    bit signed [POS_W-1:0]  px;
    bit signed [POS_W-1:0]  py;
    bit [HEAD_W-1:0]        hdg;
  } particle_t;

  typedef struct {
    bit signed [POS_W-1:0]  nx;
    bit signed [POS_W-1:0]  ny;
    bit [HEAD_W-1:0]        nh;
    bit                     moved;
  } motion_t;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  pmp_in_if  in_ch ();
  pmp_out_if out_ch ();

  particle_motion_prediction dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  // Shared run state
  motion_t expected_motion[$];
  int      mismatches  = 0;
  int      cycle_count = 0;
  int      words_sent  = 0;
  int      hold_cycles = 0;   // receiver hold-off request, counted down below
  bit      no_idle     = 1'b0; // suppress pauses on both sides

  // Predictor copy of the block's registers and step latches (reset values)
  bit signed [VEL_W-1:0]  vel_lat   = '0;
  bit signed [VEL_W-1:0]  vel_fwd   = '0;
  bit signed [YAW_W-1:0]  yaw_rate  = '0;
  bit [TIME_W-1:0]        last_tick = '0;
  bit                     step_ok   = 1'b0;
  bit signed [31:0]       dx_step   = '0;
  bit signed [31:0]       dy_step   = '0;
  bit [HEAD_W-1:0]        dyaw_step = '0;

  // --------------------------------------------------------------------------
  // Fixed-point helpers of the predictor
  // --------------------------------------------------------------------------

  // arctan(2^-i), full turn = 2^32
  function automatic longint atan_step(int i);
    case (i)
      0:  return 64'h20000000;
      1:  return 64'h12E4051E;
      2:  return 64'h09FB385B;
      3:  return 64'h051111D4;
      4:  return 64'h028B0D43;
      5:  return 64'h0145D7E1;
      6:  return 64'h00A2F61E;
      7:  return 64'h00517C55;
      8:  return 64'h0028BE53;
      9:  return 64'h00145F2F;
      10: return 64'h000A2F98;
      11: return 64'h000517CC;
      12: return 64'h00028BE6;
      13: return 64'h000145F3;
      14: return 64'h0000A2FA;
      15: return 64'h0000517D;
      16: return 64'h000028BE;
      17: return 64'h0000145F;
      18: return 64'h00000A30;
      19: return 64'h00000518;
      20: return 64'h0000028C;
      21: return 64'h00000146;
      22: return 64'h000000A3;
      23: return 64'h00000051;
      default: return 64'h0;
    endcase
  endfunction

  // round half up, then floor shift
  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic bit signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647)
      return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648)
      return 32'sh80000000;
    return v[31:0];
  endfunction

  // cos and sin of a binary-angle heading, Q1.30
  function automatic void heading_sincos(input bit [HEAD_W-1:0] h,
                                         output longint c, output longint s);
    bit [31:0] ang;
    bit        flip;
    longint    x, y, z, xn;
    int        n;
    ang  = {h, 16'h0000};
    flip = 1'b0;
    x    = GAIN_Q30;
    y    = 0;
    n    = (ANGLE_BITS_DEF > ATAN_ENTRIES) ? ATAN_ENTRIES : ANGLE_BITS_DEF;
    // fold the left half plane onto the right one and negate at the end
    if (((ang + 32'h4000_0000) & 32'h8000_0000) != 32'h0) begin
      ang  = ang + 32'h8000_0000;
      flip = 1'b1;
    end
    z = longint'($signed(ang));
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        xn = x - (y >>> i);
        y  = y + (x >>> i);
        z  = z - atan_step(i);
      end else begin
        xn = x + (y >>> i);
        y  = y - (x >>> i);
        z  = z + atan_step(i);
      end
      x = xn;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  // Advance the predictor by one accepted word and return its result word
  function automatic motion_t predict_motion(particle_t p);
    motion_t m;
    longint  dt, c, s, mx, my;
    if (p.first) begin
      // plain difference: a time below the stored one never wraps to valid
      dt = longint'({32'h0, p.stime}) - longint'({32'h0, last_tick});
      step_ok = (dt > 0) && (dt <= MAX_STEP_TICKS_DEF);
      if (step_ok) begin
        dx_step   = clamp32(round_shr(longint'(vel_lat) * dt, 10));
        dy_step   = clamp32(round_shr(longint'(vel_fwd) * dt, 10));
        mx        = round_shr(longint'(yaw_rate) * dt, 10);
        dyaw_step = mx[HEAD_W-1:0];
        last_tick = p.stime;
      end
    end
    if (!step_ok) begin
      m.nx    = p.px;
      m.ny    = p.py;
      m.nh    = p.hdg;
      m.moved = 1'b0;
      return m;
    end
    heading_sincos(p.hdg, c, s);
    mx = round_shr(longint'(dx_step) * s + longint'(dy_step) * c, 30);
    my = round_shr(longint'(dx_step) * c - longint'(dy_step) * s, 30);
    m.nx    = clamp32(longint'(p.px) + mx);
    m.ny    = clamp32(longint'(p.py) + my);
    m.nh    = p.hdg + dyaw_step;
    m.moved = 1'b1;
    return m;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_VEL_X:    vel_lat  = data;
      REG_VEL_Y:    vel_fwd  = data;
      REG_VEL_YAW:  yaw_rate = data[YAW_W-1:0];
      REG_REF_TIME: last_tick = data;   // latches and step_ok stay
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Random choices
  // --------------------------------------------------------------------------

  // Mostly short pauses, now and then a long one
  function automatic int pick_gap();
    int r;
    if (no_idle)
      return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic bit [31:0] rand_pos();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF - $urandom_range(0, 1 << 20);
      1: return 32'h8000_0000 + $urandom_range(0, 1 << 20);
      2: return $urandom_range(0, 1 << 22) - (1 << 21);
      default: return $urandom;
    endcase
  endfunction

  function automatic bit [31:0] rand_vel();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3, 4, 5: return $urandom_range(0, 1 << 23) - (1 << 22);  // within +-64 m/s
      default: return $urandom;
    endcase
  endfunction

  // Upper byte is don't-care for the 24-bit yaw rate: leave it random too
  function automatic bit [31:0] rand_yaw();
    case ($urandom_range(0, 7))
      0: return 32'h007F_FFFF;
      1: return 32'h0080_0000;
      2: return 32'h0;
      3, 4: return $urandom_range(0, 1 << 17) - (1 << 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic bit [31:0] rand_ref_time();
    case ($urandom_range(0, 9))
      0, 1: return 32'hFFFF_FFFF - $urandom_range(0, 4000);  // close to the wrap
      2, 3, 4: return $urandom;
      default: return $urandom_range(0, 1 << 20);
    endcase
  endfunction

  // Mostly a valid dt, the rest zero, too long, behind the stored time or wild
  function automatic bit [31:0] pick_step_time();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4)  return last_tick + 1;
    if (r < 8)  return last_tick + MAX_STEP_TICKS_DEF;
    if (r < 80) return last_tick + $urandom_range(1, MAX_STEP_TICKS_DEF);
    if (r < 85) return last_tick;
    if (r < 90) return last_tick + MAX_STEP_TICKS_DEF + $urandom_range(1, 5000);
    if (r < 95) return last_tick - $urandom_range(1, 5000);
    return $urandom;
  endfunction

  function automatic particle_t make_particle(bit first, bit [31:0] stime, bit [31:0] px,
                                              bit [31:0] py, bit [15:0] hdg);
    particle_t p;
    p.first = first;
    p.stime = stime;
    p.px    = px;
    p.py    = py;
    p.hdg   = hdg;
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Shared driving, checking and reporting
  // --------------------------------------------------------------------------

  task automatic report_mismatch(string msg);
    if (mismatches < 200)
      $display("MISMATCH cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // Enter and leave at a falling edge; valid is only lowered for a real pause
  task automatic send_word(particle_t p);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.first_in_step <= p.first;
    in_ch.step_time     <= p.stime;
    in_ch.pos_x         <= p.px;
    in_ch.pos_y         <= p.py;
    in_ch.heading       <= p.hdg;
    @(posedge clk);
    while (in_ch.ready !== 1'b1)
      @(posedge clk);
    expected_motion.push_back(predict_motion(p));
    words_sent++;
    @(negedge clk);
  endtask

  // Drop valid, drain every pending result, then let the block settle
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_motion.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Only called while idle; raise the enable, then lower it again
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    apply_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Receiver: a hold-off request wins, otherwise random stalls
  initial begin : ready_driver
    int stall_left;
    stall_left   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        stall_left = pick_gap();
      end
    end
  end

  // Compare each accepted result word with the oldest prediction
  always @(posedge clk) begin : check_results
    motion_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (expected_motion.size() == 0) begin
        report_mismatch($sformatf("result word with nothing pending: x=%0d y=%0d h=%0d m=%0b",
                                  out_ch.new_x, out_ch.new_y, out_ch.new_heading,
                                  out_ch.moved));
      end else begin
        want = expected_motion.pop_front();
        if (out_ch.new_x !== want.nx)
          report_mismatch($sformatf("new_x %0d, want %0d", out_ch.new_x, want.nx));
        if (out_ch.new_y !== want.ny)
          report_mismatch($sformatf("new_y %0d, want %0d", out_ch.new_y, want.ny));
        if (out_ch.new_heading !== want.nh)
          report_mismatch($sformatf("new_heading %0d, want %0d",
                                    out_ch.new_heading, want.nh));
        if (out_ch.moved !== want.moved)
          report_mismatch($sformatf("moved %0b, want %0b", out_ch.moved, want.moved));
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_particle_motion_prediction failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Words before any first word pass unchanged; their step time is ignored
  task automatic test_pass_before_step();
    send_word(make_particle(1'b0, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF));
    send_word(make_particle(1'b0, 32'h0000_0001, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0000));
    send_word(make_particle(1'b0, 32'h5555_AAAA, 32'hAAAA_5555, 32'h0000_0000, 16'h8000));
  endtask

  // dt limits, saturation, quadrant edges and register writes mid-step
  task automatic test_step_boundaries();
    wait_idle();
    write_reg(REG_VEL_X, 32'h7FFF_FFFF);
    write_reg(REG_VEL_Y, 32'h8000_0000);
    write_reg(REG_VEL_YAW, 32'h007F_FFFF);
    write_reg(REG_REF_TIME, 32'd1000);
    // zero dt, then a step time behind the stored one, then one tick too long
    send_word(make_particle(1'b1, 32'd1000, 32'd0, 32'd0, 16'h1234));
    send_word(make_particle(1'b0, 32'hFFFF_FFFF, 32'd5, 32'd7, 16'h4321));
    send_word(make_particle(1'b1, 32'd999, 32'd1, 32'd2, 16'h0001));
    send_word(make_particle(1'b1, 32'd1000 + MAX_STEP_TICKS_DEF + 1, 32'd3, 32'd4, 16'h0002));
    // longest valid step: increments saturate, positions pushed to the rails
    send_word(make_particle(1'b1, 32'd1000 + MAX_STEP_TICKS_DEF, 32'h7FFF_FFFF,
                            32'h8000_0000, 16'h0000));
    send_word(make_particle(1'b0, 32'd0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h4000));
    send_word(make_particle(1'b0, 32'd0, 32'h8000_0000, 32'h8000_0000, 16'h8000));
    send_word(make_particle(1'b0, 32'd0, 32'h7FFF_FFFF, 32'h8000_0000, 16'hC000));
    send_word(make_particle(1'b0, 32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 16'h3FFF));
    send_word(make_particle(1'b0, 32'd0, 32'h0000_0000, 32'h0000_0000, 16'hBFFF));
    send_word(make_particle(1'b0, 32'd0, 32'h0001_0000, 32'hFFFF_0000, 16'hFFFF));
    // shortest valid step
    send_word(make_particle(1'b1, 32'd1000 + MAX_STEP_TICKS_DEF + 1, 32'd0, 32'd0, 16'h2000));
    // velocity write inside a step: the open step keeps its increments
    wait_idle();
    write_reg(REG_VEL_X, 32'h0001_0000);
    send_word(make_particle(1'b0, 32'd0, 32'h0010_0000, 32'h0020_0000, 16'h1000));
    // time write inside a step: increments and step state stay
    wait_idle();
    write_reg(REG_REF_TIME, 32'hFFFF_FF00);
    send_word(make_particle(1'b0, 32'd0, 32'h0010_0000, 32'h0020_0000, 16'h6000));
    // a small time after a time near the top does not wrap into a valid dt
    send_word(make_particle(1'b1, 32'h0000_0010, 32'd11, 32'd12, 16'h7000));
    send_word(make_particle(1'b1, 32'hFFFF_FF05, 32'd13, 32'd14, 16'hE000));
  endtask

  // Hold the receiver off while the sender keeps offering words
  task automatic test_backpressure();
    wait_idle();
    write_reg(REG_VEL_X, rand_vel());
    write_reg(REG_VEL_Y, rand_vel());
    hold_cycles = 400;
    no_idle     = 1'b1;
    send_word(make_particle(1'b1, last_tick + 100, rand_pos(), rand_pos(), 16'($urandom)));
    repeat (11)
      send_word(make_particle(1'b0, $urandom, rand_pos(), rand_pos(), 16'($urandom)));
    no_idle = 1'b0;
  endtask

  // Phases of random settings, each a run of prediction steps
  task automatic test_random_steps();
    int target, steps, parts;
    target = words_sent + RANDOM_WORDS;
    while (words_sent < target) begin
      wait_idle();
      no_idle = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 3) != 0) write_reg(REG_VEL_X, rand_vel());
      if ($urandom_range(0, 3) != 0) write_reg(REG_VEL_Y, rand_vel());
      if ($urandom_range(0, 3) != 0) write_reg(REG_VEL_YAW, rand_yaw());
      if ($urandom_range(0, 1) != 0) write_reg(REG_REF_TIME, rand_ref_time());
      // sometimes carry on with the step left open by the last phase
      if ($urandom_range(0, 3) == 0) begin
        parts = $urandom_range(1, 4);
        repeat (parts)
          send_word(make_particle(1'b0, $urandom, rand_pos(), rand_pos(), 16'($urandom)));
      end
      steps = $urandom_range(2, 8);
      repeat (steps) begin
        send_word(make_particle(1'b1, pick_step_time(), rand_pos(), rand_pos(),
                                16'($urandom)));
        parts = $urandom_range(0, 10);
        repeat (parts)
          send_word(make_particle(1'b0, $urandom, rand_pos(), rand_pos(), 16'($urandom)));
      end
    end
    no_idle = 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_index           = REG_VEL_X;
    cfg_data            = '0;
    in_ch.valid         = 1'b0;
    in_ch.first_in_step = 1'b0;
    in_ch.step_time     = '0;
    in_ch.pos_x         = '0;
    in_ch.pos_y         = '0;
    in_ch.heading       = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_pass_before_step();
    test_step_boundaries();
    test_backpressure();
    test_random_steps();

    // drain, then watch for stray words
    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_motion.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", expected_motion.size()));
    if (mismatches == 0)
      $display("tb_particle_motion_prediction passed");
    else
      $display("tb_particle_motion_prediction failed");
    $finish;
  end

endmodule

### filelist.f
design/pmp_pkg.sv
design/pmp_if.sv
design/pmp_step_mul.sv
design/pmp_cordic.sv
design/pmp_rot_mul.sv
design/particle_motion_prediction.sv
sim/tb_particle_motion_prediction.sv
